// ===== rtl/fml_pkg.sv =====
// Shared constants, types and the luma function for the frame mean luma block.
package fml_pkg;

    localparam int MAX_PIXELS_LOG2 = 22;

    localparam int CHAN_W  = 8;
    localparam int LUMA_W  = 24;
    localparam int FRAC_W  = 8;
    localparam int MEAN_W  = 16;
    localparam int COUNT_W = 23;

    localparam int CNT_W      = MAX_PIXELS_LOG2 + 1;
    localparam int SUM_W      = LUMA_W + MAX_PIXELS_LOG2;
    localparam int REM_INIT_W = SUM_W - FRAC_W - MEAN_W;

    localparam logic [CNT_W-1:0] PIXEL_LIMIT = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

    localparam int DIV_STEPS = MEAN_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    localparam logic [LUMA_W-1:0] W_RED   = 24'd19595;
    localparam logic [LUMA_W-1:0] W_GREEN = 24'd38470;
    localparam logic [LUMA_W-1:0] W_BLUE  = 24'd7471;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic out_load;
    } fml_cmd_t;

    typedef struct packed {
        logic out_free;
    } fml_status_t;

    function automatic logic [LUMA_W-1:0] luma_q8_16(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        logic [LUMA_W-1:0] pr;
        logic [LUMA_W-1:0] pg;
        logic [LUMA_W-1:0] pb;
        pr = W_RED   * LUMA_W'(r);
        pg = W_GREEN * LUMA_W'(g);
        pb = W_BLUE  * LUMA_W'(b);
        return pr + pg + pb;
    endfunction

endpackage

// ===== rtl/fml_pixel_if.sv =====
// Pixel channel: valid/ready handshake carrying one RGB pixel item.
interface fml_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [fml_pkg::CHAN_W-1:0] red;
    logic [fml_pkg::CHAN_W-1:0] green;
    logic [fml_pkg::CHAN_W-1:0] blue;
    logic                       last_pixel;

    modport source (output valid, output red, output green, output blue,
                    output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_pixel, output ready);
endinterface

// ===== rtl/fml_mean_if.sv =====
// Result channel: valid/ready handshake carrying one frame mean item.
interface fml_mean_if;
    logic                        valid;
    logic                        ready;
    logic [fml_pkg::MEAN_W-1:0]  mean_luma;
    logic [fml_pkg::COUNT_W-1:0] pixels_counted;
    logic                        count_overflow;

    modport source (output valid, output mean_luma, output pixels_counted,
                    output count_overflow, input ready);
    modport sink   (input valid, input mean_luma, input pixels_counted,
                    input count_overflow, output ready);
endinterface

// ===== rtl/fml_ctrl.sv =====
// Controller: sequences accumulation, settle, divider load, division steps and result hand-off.
module fml_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  fml_pkg::fml_status_t status,
    output fml_pkg::fml_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ACCUM,
        SETTLE,
        LOAD,
        DIVIDE,
        FINISH
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [fml_pkg::STEP_W-1:0]  step_reg;
    logic [fml_pkg::STEP_W-1:0]  step_next;

    assign in_ready = (state_reg == ACCUM);

    always_comb
    begin
        cmd.accept   = in_valid && in_ready;
        cmd.load     = (state_reg == LOAD);
        cmd.step     = (state_reg == DIVIDE);
        cmd.out_load = (state_reg == FINISH) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ACCUM:
            begin
                if (in_valid && in_last)
                begin
                    state_next = SETTLE;
                end
            end
            SETTLE:
            begin
                state_next = LOAD;
            end
            LOAD:
            begin
                step_next  = '0;
                state_next = DIVIDE;
            end
            DIVIDE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == fml_pkg::LAST_STEP)
                begin
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ACCUM;
                end
            end
            default:
            begin
                state_next = ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ACCUM;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/fml_datapath.sv =====
// Datapath: luma stage, frame accumulator, restoring divider and result register.
module fml_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fml_pkg::fml_cmd_t            cmd,
    output fml_pkg::fml_status_t         status,
    input  logic [fml_pkg::CHAN_W-1:0]   red,
    input  logic [fml_pkg::CHAN_W-1:0]   green,
    input  logic [fml_pkg::CHAN_W-1:0]   blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fml_pkg::MEAN_W-1:0]   mean_luma,
    output logic [fml_pkg::COUNT_W-1:0]  pixels_counted,
    output logic                         count_overflow
);

    logic [fml_pkg::LUMA_W-1:0]  luma_reg;
    logic                        luma_valid_reg;
    logic [fml_pkg::SUM_W-1:0]   sum_reg;
    logic [fml_pkg::CNT_W-1:0]   cnt_reg;
    logic                        ovf_reg;

    logic [fml_pkg::CNT_W-1:0]   rem_reg;
    logic [fml_pkg::CNT_W-1:0]   rem_next;
    logic [fml_pkg::MEAN_W-1:0]  dvd_reg;
    logic [fml_pkg::MEAN_W-1:0]  dvd_next;
    logic [fml_pkg::CNT_W-1:0]   den_reg;
    logic                        div_ovf_reg;

    logic [fml_pkg::CNT_W:0]     trial;
    logic [fml_pkg::CNT_W:0]     den_ext;
    logic [fml_pkg::CNT_W:0]     diff;
    logic                        fits;

    logic                        out_valid_reg;
    logic [fml_pkg::MEAN_W-1:0]  mean_reg;
    logic [fml_pkg::COUNT_W-1:0] count_out_reg;
    logic                        ovf_out_reg;

    assign status.out_free = !out_valid_reg || out_ready;

    // Luma stage: hold one pixel's luma for the accumulator.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            luma_reg <= fml_pkg::luma_q8_16(red, green, blue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_valid_reg <= 1'b0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            luma_valid_reg <= cmd.accept && (cnt_reg != fml_pkg::PIXEL_LIMIT);
            if (cmd.load)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                if (luma_valid_reg)
                begin
                    sum_reg <= sum_reg + fml_pkg::SUM_W'(luma_reg);
                end
                if (cmd.accept)
                begin
                    if (cnt_reg == fml_pkg::PIXEL_LIMIT)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Restoring division of sum/256 by the count, one quotient bit per step.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[fml_pkg::MEAN_W-1]};
        den_ext  = {1'b0, den_reg};
        diff     = trial - den_ext;
        fits     = (trial >= den_ext);
        rem_next = fits ? diff[fml_pkg::CNT_W-1:0] : trial[fml_pkg::CNT_W-1:0];
        dvd_next = {dvd_reg[fml_pkg::MEAN_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg     <= {1'b0, sum_reg[fml_pkg::SUM_W-1 -: fml_pkg::REM_INIT_W]};
            dvd_reg     <= sum_reg[fml_pkg::FRAC_W +: fml_pkg::MEAN_W];
            den_reg     <= cnt_reg;
            div_ovf_reg <= ovf_reg;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mean_reg      <= dvd_reg;
            count_out_reg <= fml_pkg::COUNT_W'(den_reg);
            ovf_out_reg   <= div_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mean_luma      = mean_reg;
    assign pixels_counted = count_out_reg;
    assign count_overflow = ovf_out_reg;

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fml_pkg::PIXEL_LIMIT)
        else $error("pixel count above limit");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> den_reg != '0)
        else $error("division by zero count");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || out_ready)
        else $error("result register overwritten");

endmodule

// ===== rtl/frame_mean_luma.sv =====
// Top level: mean Rec.601 luma of a frame of RGB pixel items.
// Throughput: one pixel item per cycle within a frame; the input stalls after its last pixel.
// Result valid follows settle, divider load, the 16-step divider and the result load in finish.
// The next frame is taken only once the frame's result is loaded into a free result register.
// Reset: rst_n asynchronous, active low; clears sum, count, overflow flag and all valid state.
module frame_mean_luma (
    input  logic        clk,
    input  logic        rst_n,
    fml_pixel_if.sink   pixel,
    fml_mean_if.source  result
);

    fml_pkg::fml_cmd_t    cmd;
    fml_pkg::fml_status_t status;

    fml_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_last  (pixel.last_pixel),
        .in_ready (pixel.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fml_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .red            (pixel.red),
        .green          (pixel.green),
        .blue           (pixel.blue),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .mean_luma      (result.mean_luma),
        .pixels_counted (result.pixels_counted),
        .count_overflow (result.count_overflow)
    );

endmodule

// ===== bench/frame_mean_luma_check.sv =====
// Checker for frame_mean_luma: predicts each frame's mean luma and compares results.
`timescale 1ns / 1ps

module frame_mean_luma_check (
    input  logic clk,
    input  logic rst_n,
    fml_pixel_if pixel,
    fml_mean_if  result,
    output int   errors,
    output int   outstanding,
    output int   results_checked
);

    localparam logic [fml_pkg::COUNT_W-1:0] FRAME_CAP =
        {1'b1, {fml_pkg::MAX_PIXELS_LOG2{1'b0}}};

    typedef struct packed {
        logic [fml_pkg::MEAN_W-1:0]  mean;
        logic [fml_pkg::COUNT_W-1:0] count;
        logic                        overflow;
    } frame_mean_t;

    frame_mean_t                  expected_means[$];
    logic [fml_pkg::SUM_W-1:0]    frame_luma_sum;
    logic [fml_pkg::COUNT_W-1:0]  frame_pixel_count;
    logic                         frame_overflow;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [fml_pkg::LUMA_W-1:0] pixel_luma(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        return fml_pkg::LUMA_W'(19595) * fml_pkg::LUMA_W'(r)
             + fml_pkg::LUMA_W'(38470) * fml_pkg::LUMA_W'(g)
             + fml_pkg::LUMA_W'(7471) * fml_pkg::LUMA_W'(b);
    endfunction

    function automatic frame_mean_t close_frame(
        input logic [fml_pkg::SUM_W-1:0]   sum,
        input logic [fml_pkg::COUNT_W-1:0] count,
        input logic                        overflow
    );
        frame_mean_t res;
        logic [63:0] quotient;
        quotient = 64'(sum) / (64'(count) << fml_pkg::FRAC_W);
        res.mean = quotient[fml_pkg::MEAN_W-1:0];
        res.count = count;
        res.overflow = overflow;
        return res;
    endfunction

    initial begin
        errors = 0;
        outstanding = 0;
        results_checked = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        frame_mean_t want;
        if (!rst_n) begin
            frame_luma_sum = '0;
            frame_pixel_count = '0;
            frame_overflow = 1'b0;
            expected_means.delete();
        end else begin
            if (pixel.valid && pixel.ready) begin
                if (frame_pixel_count == FRAME_CAP) begin
                    frame_overflow = 1'b1;
                end else begin
                    frame_luma_sum = frame_luma_sum
                        + fml_pkg::SUM_W'(pixel_luma(pixel.red, pixel.green, pixel.blue));
                    frame_pixel_count = frame_pixel_count + 1'b1;
                end
                if (pixel.last_pixel) begin
                    expected_means.push_back(
                        close_frame(frame_luma_sum, frame_pixel_count, frame_overflow));
                    frame_luma_sum = '0;
                    frame_pixel_count = '0;
                    frame_overflow = 1'b0;
                end
            end
            if (result.valid && result.ready) begin
                if (expected_means.size() == 0) begin
                    report_mismatch($sformatf("result with no frame pending, mean %0d",
                                              result.mean_luma));
                end else begin
                    want = expected_means.pop_front();
                    results_checked++;
                    if (result.mean_luma !== want.mean)
                        report_mismatch($sformatf("mean_luma got %0d, expected %0d",
                                                  result.mean_luma, want.mean));
                    if (result.pixels_counted !== want.count)
                        report_mismatch($sformatf("pixels_counted got %0d, expected %0d",
                                                  result.pixels_counted, want.count));
                    if (result.count_overflow !== want.overflow)
                        report_mismatch($sformatf("count_overflow got %0b, expected %0b",
                                                  result.count_overflow, want.overflow));
                end
            end
        end
        outstanding = expected_means.size();
    end

endmodule

// ===== bench/frame_mean_luma_test.sv =====
// Testbench top for frame_mean_luma: pixel stimulus, result back-pressure, watchdog, verdict.
`timescale 1ns / 1ps

module frame_mean_luma_test;

    localparam int RANDOM_PIXELS   = 430;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 40;

    logic clk;
    logic rst_n;
    logic hold_off_request;
    int   errors;
    int   outstanding;
    int   results_checked;
    int   pixels_sent;
    int   frames_sent;
    int   idle_cycles;

    fml_pixel_if pixel ();
    fml_mean_if  result ();

    frame_mean_luma dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .result (result)
    );

    frame_mean_luma_check checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel           (pixel),
        .result          (result),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    function automatic logic [fml_pkg::CHAN_W-1:0] random_channel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return fml_pkg::CHAN_W'($urandom_range(255));
        endcase
    endfunction

    function automatic int random_frame_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(1, 8);
        else if (roll < 95)
            return $urandom_range(9, 40);
        else
            return $urandom_range(41, 120);
    endfunction

    task automatic send_pixel(
        input logic [fml_pkg::CHAN_W-1:0] r,
        input logic [fml_pkg::CHAN_W-1:0] g,
        input logic [fml_pkg::CHAN_W-1:0] b,
        input logic                       last,
        input bit                         steady
    );
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            pixel.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel.valid      <= 1'b1;
        pixel.red        <= r;
        pixel.green      <= g;
        pixel.blue       <= b;
        pixel.last_pixel <= last;
        @(posedge clk);
        while (!pixel.ready) @(posedge clk);
        pixels_sent++;
        if (last)
            frames_sent++;
    endtask

    task automatic send_random_frame(input int size, input bit steady);
        for (int i = 0; i < size; i++)
            send_pixel(random_channel(), random_channel(), random_channel(),
                       i == size - 1, steady);
    endtask

    task automatic drain_results();
        pixel.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n || (pixel.valid && pixel.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no item moved for %0d cycles", IDLE_LIMIT);
            $display("frame_mean_luma_test failed");
            $finish;
        end
    end

    initial begin
        int gap;
        result.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                result.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                result.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                gap = pick_gap();
                if (gap != 0) begin
                    result.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial begin
        int random_start;
        rst_n            = 1'b0;
        hold_off_request = 1'b0;
        idle_cycles      = 0;
        pixels_sent      = 0;
        frames_sent      = 0;
        pixel.valid      = 1'b0;
        pixel.red        = '0;
        pixel.green      = '0;
        pixel.blue       = '0;
        pixel.last_pixel = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pixel frames at the extremes
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b1, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b1, 1'b0);
        // short frames, alternating bit patterns, floored means
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b0, 1'b0);
        send_pixel(8'h01, 8'h80, 8'hFE, 1'b1, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h01, 1'b1, 1'b1);
        send_pixel(8'h80, 8'h80, 8'h80, 1'b0, 1'b0);
        send_pixel(8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0);
        drain_results();

        // back-pressure: hold the result side while pixels keep coming
        hold_off_request = 1'b1;
        random_start = pixels_sent;
        repeat (12) send_random_frame($urandom_range(1, 4), 1'b1);
        drain_results();

        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            send_random_frame(random_frame_size(), $urandom_range(3) == 0);
            if ($urandom_range(15) == 0)
                drain_results();
        end
        pixel.valid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d pixels in %0d frames, including a long result hold-off",
                 pixels_sent, frames_sent);
        $display("checked %0d frame means under random stalls on both sides",
                 results_checked);
        if (errors == 0 && outstanding == 0)
            $display("frame_mean_luma_test passed");
        else
            $display("frame_mean_luma_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fml_pkg.sv
rtl/fml_pixel_if.sv
rtl/fml_mean_if.sv
rtl/fml_ctrl.sv
rtl/fml_datapath.sv
rtl/frame_mean_luma.sv
bench/frame_mean_luma_check.sv
bench/frame_mean_luma_test.sv
